### hw/rtl/modexp_pkg.sv
package modexp_pkg;

    localparam int OPERAND_BITS = 31;
    localparam int CNT_W = $clog2(OPERAND_BITS);
    localparam int CFG_INDEX_W = 2;

    localparam logic [CFG_INDEX_W-1:0] REG_MODULUS = CFG_INDEX_W'(0);
    localparam logic [CFG_INDEX_W-1:0] REG_EXPONENT = CFG_INDEX_W'(1);

    typedef logic [OPERAND_BITS-1:0] operand_t;
    typedef logic [CNT_W-1:0] count_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_REDUCE,
        ST_SCAN,
        ST_SQUARE,
        ST_MULT,
        ST_DONE
    } state_t;

endpackage

### hw/rtl/modular_exponentiation.sv
// Modular exponentiation: each input word carries a base, and the block returns
// base to the power of the exponent register, modulo the modulus register.
// Configuration is written through cfg_write, cfg_index and cfg_data: index 0 is
// the modulus, index 1 the exponent; other indexes are ignored. A modulus of zero
// acts as one, and an exponent of zero always returns 1.
// The input channel takes a word when in_valid is high and in_stall is low; the
// block then holds in_stall high until the result has entered the output register.
// A single modular multiplier handles one multiplier bit per cycle. The base is
// first reduced, the exponent is scanned for its leading one at one bit per
// cycle, and each exponent bit then costs one squaring plus, for a set bit, one
// multiplication. The next word is accepted in the cycle after a result is
// loaded, so the block works on one word at a time.
// The result sits in an output register until taken; while out_stall is high it
// holds, and the next word may already be accepted and computed behind it.
// Reset sets the modulus to 1 and the exponent to 0 and empties the block.
module modular_exponentiation
    import modexp_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_write,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [OPERAND_BITS-1:0] cfg_data,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  logic [OPERAND_BITS-1:0] base,
    output logic                   out_valid,
    input  logic                   out_stall,
    output logic [OPERAND_BITS-1:0] power_mod
);

    localparam int W = OPERAND_BITS;

    state_t   state_reg, state_next;
    operand_t modulus_reg, exponent_reg;
    operand_t n_reg, n_next;
    operand_t x_reg, x_next;
    operand_t y_reg, y_next;
    operand_t acc_reg, acc_next;
    operand_t e_reg, e_next;
    operand_t b_reg, b_next;
    operand_t d_reg, d_next;
    operand_t power_mod_reg, power_mod_next;
    count_t   cnt_reg, cnt_next;
    count_t   ecnt_reg, ecnt_next;
    logic     out_valid_reg, out_valid_next;

    logic     in_accept;
    logic     out_free;
    operand_t n_sel;
    operand_t one_sel;
    operand_t one_cur;
    logic [W+2:0] sum_val, diff1, diff2;
    operand_t step_res;
    count_t   last_cnt;

    assign in_accept = in_valid && (state_reg == ST_IDLE);
    assign out_free  = !out_valid_reg || !out_stall;
    assign n_sel     = (modulus_reg == '0) ? operand_t'(1) : modulus_reg;
    assign one_sel   = (n_sel == operand_t'(1)) ? '0 : operand_t'(1);
    assign one_cur   = (n_reg == operand_t'(1)) ? '0 : operand_t'(1);
    assign last_cnt  = count_t'(W - 1);

    // One step of the shift-and-add reducer: acc = (2 * acc + bit * x) mod n,
    // where acc, x < n, so the sum stays below 3n.
    always_comb
    begin
        sum_val = {2'b00, acc_reg, 1'b0} + (y_reg[W-1] ? {3'b000, x_reg} : '0);
        diff1 = sum_val - {3'b000, n_reg};
        diff2 = sum_val - {2'b00, n_reg, 1'b0};
        if (!diff2[W+2])
        begin
            step_res = diff2[W-1:0];
        end
        else if (!diff1[W+2])
        begin
            step_res = diff1[W-1:0];
        end
        else
        begin
            step_res = sum_val[W-1:0];
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    state_next = (exponent_reg == '0) ? ST_DONE : ST_REDUCE;
                end
            end
            ST_REDUCE:
            begin
                if (cnt_reg == '0)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (e_reg[W-1])
                begin
                    state_next = ST_SQUARE;
                end
            end
            ST_SQUARE:
            begin
                if (cnt_reg == '0)
                begin
                    if (e_reg[W-1])
                    begin
                        state_next = ST_MULT;
                    end
                    else if (ecnt_reg == '0)
                    begin
                        state_next = ST_DONE;
                    end
                end
            end
            ST_MULT:
            begin
                if (cnt_reg == '0)
                begin
                    state_next = (ecnt_reg == '0) ? ST_DONE : ST_SQUARE;
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        n_next         = n_reg;
        x_next         = x_reg;
        y_next         = y_reg;
        acc_next       = acc_reg;
        e_next         = e_reg;
        b_next         = b_reg;
        d_next         = d_reg;
        cnt_next       = cnt_reg;
        ecnt_next      = ecnt_reg;
        power_mod_next = power_mod_reg;
        out_valid_next = out_valid_reg && out_stall;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    n_next    = n_sel;
                    x_next    = one_sel;
                    y_next    = base;
                    acc_next  = '0;
                    cnt_next  = last_cnt;
                    e_next    = exponent_reg;
                    ecnt_next = last_cnt;
                    d_next    = operand_t'(1);
                end
            end
            ST_REDUCE:
            begin
                acc_next = step_res;
                y_next   = {y_reg[W-2:0], 1'b0};
                cnt_next = cnt_reg - count_t'(1);
                if (cnt_reg == '0)
                begin
                    b_next = step_res;
                end
            end
            ST_SCAN:
            begin
                if (e_reg[W-1])
                begin
                    d_next   = one_cur;
                    x_next   = one_cur;
                    y_next   = one_cur;
                    acc_next = '0;
                    cnt_next = last_cnt;
                end
                else
                begin
                    e_next    = {e_reg[W-2:0], 1'b0};
                    ecnt_next = ecnt_reg - count_t'(1);
                end
            end
            ST_SQUARE, ST_MULT:
            begin
                acc_next = step_res;
                y_next   = {y_reg[W-2:0], 1'b0};
                cnt_next = cnt_reg - count_t'(1);
                if (cnt_reg == '0)
                begin
                    d_next   = step_res;
                    acc_next = '0;
                    cnt_next = last_cnt;
                    if ((state_reg == ST_SQUARE) && e_reg[W-1])
                    begin
                        x_next = step_res;
                        y_next = b_reg;
                    end
                    else
                    begin
                        x_next    = step_res;
                        y_next    = step_res;
                        e_next    = {e_reg[W-2:0], 1'b0};
                        ecnt_next = ecnt_reg - count_t'(1);
                    end
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    power_mod_next = d_reg;
                    out_valid_next = 1'b1;
                end
            end
            default:
            begin
                out_valid_next = out_valid_reg && out_stall;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            modulus_reg   <= operand_t'(1);
            exponent_reg  <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (cfg_write && (cfg_index == REG_MODULUS))
            begin
                modulus_reg <= cfg_data;
            end
            if (cfg_write && (cfg_index == REG_EXPONENT))
            begin
                exponent_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg         <= n_next;
        x_reg         <= x_next;
        y_reg         <= y_next;
        acc_reg       <= acc_next;
        e_reg         <= e_next;
        b_reg         <= b_next;
        d_reg         <= d_next;
        cnt_reg       <= cnt_next;
        ecnt_reg      <= ecnt_next;
        power_mod_reg <= power_mod_next;
    end

    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;
    assign power_mod = power_mod_reg;

endmodule

### hw/rtl/modexp_checker.sv
module modexp_checker
    import modexp_pkg::*;
(
    input logic                    clk,
    input logic                    rst_n,
    input logic                    in_valid,
    input logic                    in_stall,
    input logic                    out_valid,
    input logic                    out_stall,
    input logic [OPERAND_BITS-1:0] power_mod
);

    // A stalled result word stays in place.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(power_mod))
    else $error("stalled result word changed");

    // An accepted word keeps the block busy in the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
    else $error("block not busy after accepting a word");

    // A new result appears only at the end of a busy period.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_stall))
    else $error("result word appeared while the block was idle");

endmodule

bind modular_exponentiation modexp_checker u_modexp_checker (.*);

### test/tb_modular_exponentiation.sv
module tb_modular_exponentiation
    import modexp_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_HALF = 6;
    localparam int RESET_CYCLES = 8;
    localparam int RANDOM_PHASES = 23;
    localparam int WORDS_PER_PHASE = 12;
    localparam int PRESSURE_PHASE = 3;
    localparam int PRESSURE_CYCLES = 1500;
    localparam int TAIL_CYCLES = 2100;
    localparam int DRAIN_LIMIT = 5000;
    localparam longint LIMIT_NS = 64'd36_000_000;
    localparam int DIRECTED_ROWS = 32;

    localparam logic [CFG_INDEX_W-1:0] REG_SPARE_2 = CFG_INDEX_W'(2);
    localparam logic [CFG_INDEX_W-1:0] REG_SPARE_3 = CFG_INDEX_W'(3);
    localparam operand_t ALL_ONES = '1;

    typedef enum logic [1:0] {
        ROW_WRITE,
        ROW_BASE,
        ROW_BASE_KNOWN
    } row_kind_t;

    typedef struct packed {
        row_kind_t kind;
        logic [CFG_INDEX_W-1:0] index;
        operand_t value;
        operand_t power;
    } stim_row_t;

    typedef struct {
        operand_t base;
        operand_t power;
        int unsigned word_num;
    } power_entry_t;

    logic clk = 1'b0;
    logic rst_n;
    logic cfg_write;
    logic [CFG_INDEX_W-1:0] cfg_index;
    operand_t cfg_data;
    logic in_valid;
    logic in_stall;
    operand_t base;
    logic out_valid;
    logic out_stall;
    operand_t power_mod;

    operand_t modulus_shadow;
    operand_t exponent_shadow;
    power_entry_t pending_powers[$];
    int unsigned error_count;
    int unsigned words_sent;
    int unsigned results_seen;
    int unsigned writes_done;
    bit no_gaps;
    bit pressure_req;

    stim_row_t directed_rows [DIRECTED_ROWS] = '{
        '{ROW_BASE_KNOWN, REG_MODULUS, 31'h0, 31'h1},
        '{ROW_BASE_KNOWN, REG_MODULUS, ALL_ONES, 31'h1},
        '{ROW_WRITE, REG_EXPONENT, 31'h5, 31'h0},
        '{ROW_BASE_KNOWN, REG_MODULUS, 31'h7, 31'h0},
        '{ROW_WRITE, REG_MODULUS, 31'h0, 31'h0},
        '{ROW_BASE_KNOWN, REG_MODULUS, 31'd123, 31'h0},
        '{ROW_WRITE, REG_SPARE_2, ALL_ONES, 31'h0},
        '{ROW_WRITE, REG_SPARE_3, ALL_ONES, 31'h0},
        '{ROW_BASE_KNOWN, REG_MODULUS, ALL_ONES, 31'h0},
        '{ROW_WRITE, REG_MODULUS, ALL_ONES, 31'h0},
        '{ROW_WRITE, REG_EXPONENT, 31'h0, 31'h0},
        '{ROW_BASE_KNOWN, REG_MODULUS, ALL_ONES, 31'h1},
        '{ROW_WRITE, REG_EXPONENT, 31'h1, 31'h0},
        '{ROW_BASE_KNOWN, REG_MODULUS, ALL_ONES, 31'h0},
        '{ROW_BASE_KNOWN, REG_MODULUS, 31'h7FFF_FFFE, 31'h7FFF_FFFE},
        '{ROW_BASE_KNOWN, REG_MODULUS, 31'h0, 31'h0},
        '{ROW_WRITE, REG_EXPONENT, ALL_ONES, 31'h0},
        '{ROW_BASE, REG_MODULUS, 31'h2, 31'h0},
        '{ROW_BASE_KNOWN, REG_MODULUS, 31'h7FFF_FFFE, 31'h7FFF_FFFE},
        '{ROW_BASE_KNOWN, REG_MODULUS, 31'h1, 31'h1},
        '{ROW_BASE, REG_MODULUS, 31'h1234_5678, 31'h0},
        '{ROW_WRITE, REG_MODULUS, 31'd13, 31'h0},
        '{ROW_WRITE, REG_EXPONENT, 31'h2, 31'h0},
        '{ROW_BASE, REG_MODULUS, 31'd100, 31'h0},
        '{ROW_BASE_KNOWN, REG_MODULUS, 31'h5, 31'd12},
        '{ROW_WRITE, REG_MODULUS, 31'h2, 31'h0},
        '{ROW_WRITE, REG_EXPONENT, 31'h4000_0000, 31'h0},
        '{ROW_BASE_KNOWN, REG_MODULUS, 31'h3, 31'h1},
        '{ROW_BASE_KNOWN, REG_MODULUS, 31'h4, 31'h0},
        '{ROW_WRITE, REG_MODULUS, 31'h1, 31'h0},
        '{ROW_WRITE, REG_EXPONENT, 31'h0, 31'h0},
        '{ROW_BASE_KNOWN, REG_MODULUS, 31'h2AAA_AAAA, 31'h1}
    };

    modular_exponentiation u_dut (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_write(cfg_write),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .base(base),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .power_mod(power_mod)
    );

    always
    begin
        #(CLK_HALF) clk = 1'b1;
        #(CLK_HALF) clk = 1'b0;
    end

    function automatic operand_t predict_power(operand_t b, operand_t n_reg, operand_t e);
        longint unsigned n;
        longint unsigned b_red;
        longint unsigned acc;
        n = (n_reg == '0) ? 64'd1 : 64'(n_reg);
        if (e == '0)
        begin
            return operand_t'(1);
        end
        b_red = 64'(b) % n;
        acc = 64'd1 % n;
        for (int i = OPERAND_BITS - 1; i >= 0; i--)
        begin
            acc = (acc * acc) % n;
            if (e[i])
            begin
                acc = (acc * b_red) % n;
            end
        end
        return operand_t'(acc);
    endfunction

    task automatic report_mismatch(input string msg);
        $display("[%0t] error: %s", $realtime, msg);
        error_count++;
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        while (pending_powers.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input operand_t data);
        wait_idle();
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
        cfg_write <= 1'b0;
        if (idx == REG_MODULUS)
        begin
            modulus_shadow = data;
        end
        else if (idx == REG_EXPONENT)
        begin
            exponent_shadow = data;
        end
        writes_done++;
        @(posedge clk);
    endtask

    task automatic send_base(input operand_t b, input bit known, input operand_t known_power);
        int unsigned gap;
        power_entry_t entry;
        gap = no_gaps ? 0 : $urandom_range(0, 7);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        base <= b;
        do
            @(posedge clk);
        while (!(in_valid && !in_stall));
        entry.base = b;
        entry.power = known ? known_power : predict_power(b, modulus_shadow, exponent_shadow);
        entry.word_num = words_sent;
        pending_powers.push_back(entry);
        words_sent++;
    endtask

    function automatic operand_t pick_modulus();
        case ($urandom_range(0, 5))
            0: return operand_t'(0);
            1: return operand_t'(1);
            2: return ALL_ONES;
            3: return operand_t'($urandom_range(2, 255));
            default: return operand_t'($urandom());
        endcase
    endfunction

    function automatic operand_t pick_exponent(input bit short_only);
        int unsigned w;
        w = $urandom_range(1, short_only ? 6 : 10);
        if (!short_only)
        begin
            case ($urandom_range(0, 7))
                0: return operand_t'(0);
                1: return ALL_ONES;
                2: return operand_t'($urandom());
                default: ;
            endcase
        end
        return operand_t'($urandom_range(1, (1 << w) - 1));
    endfunction

    function automatic operand_t pick_base();
        longint unsigned n;
        n = (modulus_shadow == '0) ? 64'd1 : 64'(modulus_shadow);
        case ($urandom_range(0, 4))
            0: return operand_t'(0);
            1: return ALL_ONES;
            2: return operand_t'(64'($urandom()) % n);
            default: return operand_t'($urandom());
        endcase
    endfunction

    initial
    begin : result_checker
        int unsigned hold;
        power_entry_t entry;
        out_stall <= 1'b0;
        @(posedge clk);
        while (!rst_n)
        begin
            @(posedge clk);
        end
        forever
        begin
            if (pressure_req)
            begin
                pressure_req = 1'b0;
                hold = PRESSURE_CYCLES;
            end
            else if (no_gaps)
            begin
                hold = 0;
            end
            else
            begin
                hold = $urandom_range(0, 7);
            end
            if (hold > 0)
            begin
                out_stall <= 1'b1;
                repeat (hold) @(posedge clk);
            end
            out_stall <= 1'b0;
            do
                @(posedge clk);
            while (!(out_valid && !out_stall));
            results_seen++;
            if (pending_powers.size() == 0)
            begin
                report_mismatch($sformatf("unexpected word power_mod=%h", power_mod));
            end
            else
            begin
                entry = pending_powers.pop_front();
                if (power_mod !== entry.power)
                begin
                    report_mismatch($sformatf("word %0d base=%h: power_mod=%h, wanted %h",
                        entry.word_num, entry.base, power_mod, entry.power));
                end
            end
        end
    end

    initial
    begin : stimulus
        int unsigned drain_cycles;
        bit short_exp;
        rst_n <= 1'b0;
        cfg_write <= 1'b0;
        cfg_index <= REG_MODULUS;
        cfg_data <= '0;
        in_valid <= 1'b0;
        base <= '0;
        modulus_shadow = operand_t'(1);
        exponent_shadow = '0;
        error_count = 0;
        words_sent = 0;
        results_seen = 0;
        writes_done = 0;
        no_gaps = 1'b0;
        pressure_req = 1'b0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int r = 0; r < DIRECTED_ROWS; r++)
        begin
            case (directed_rows[r].kind)
                ROW_WRITE: write_reg(directed_rows[r].index, directed_rows[r].value);
                ROW_BASE: send_base(directed_rows[r].value, 1'b0, '0);
                default: send_base(directed_rows[r].value, 1'b1, directed_rows[r].power);
            endcase
        end

        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            short_exp = (p == PRESSURE_PHASE);
            if (short_exp || $urandom_range(0, 3) != 0)
            begin
                write_reg(REG_MODULUS, pick_modulus());
            end
            if ($urandom_range(0, 5) == 0)
            begin
                write_reg($urandom_range(0, 1) ? REG_SPARE_2 : REG_SPARE_3,
                    operand_t'($urandom()));
            end
            if (short_exp || $urandom_range(0, 3) != 0)
            begin
                write_reg(REG_EXPONENT, pick_exponent(short_exp));
            end
            no_gaps = ($urandom_range(0, 3) == 0);
            if (short_exp)
            begin
                pressure_req = 1'b1;
            end
            for (int k = 0; k < WORDS_PER_PHASE; k++)
            begin
                send_base(pick_base(), 1'b0, '0);
            end
        end
        in_valid <= 1'b0;
        no_gaps = 1'b0;

        drain_cycles = 0;
        while (pending_powers.size() != 0 && drain_cycles < DRAIN_LIMIT)
        begin
            @(posedge clk);
            drain_cycles++;
        end
        repeat (TAIL_CYCLES) @(posedge clk);
        if (pending_powers.size() != 0)
        begin
            report_mismatch($sformatf("%0d words never returned", pending_powers.size()));
        end

        $display("Sent %0d bases and checked %0d results across %0d register writes,",
            words_sent, results_seen, writes_done);
        $display("covering modulus 0/1/max, exponent 0/max, and a long output back-pressure.");
        if (error_count == 0)
        begin
            $display("SCOREBOARD CLEAN");
        end
        else
        begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    initial
    begin : watchdog
        #(LIMIT_NS);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
